@@ sv/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RLN_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rln assertion failed");

// Next-cycle implication, disabled during reset.
`define RLN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rln assertion failed");

`endif

@@ sv/rln_pkg.sv @@
// Types and codes for the leader election node.
// No dependencies; used by every module of the block.
`default_nettype none
package rln_pkg;

   localparam logic [3:0] MODE_TICK        = 4'd0;
   localparam logic [3:0] MODE_TIMEOUT     = 4'd1;
   localparam logic [3:0] MODE_LOYAL_END   = 4'd2;
   localparam logic [3:0] MODE_DEMOTE      = 4'd3;
   localparam logic [3:0] MODE_APPEND      = 4'd4;
   localparam logic [3:0] MODE_VOTE_REQ    = 4'd5;
   localparam logic [3:0] MODE_APPEND_RPL  = 4'd6;
   localparam logic [3:0] MODE_VOTE_RPL    = 4'd7;
   localparam logic [3:0] MODE_START       = 4'd8;

   localparam logic [2:0] KIND_NONE        = 3'd0;
   localparam logic [2:0] KIND_APPEND      = 3'd1;
   localparam logic [2:0] KIND_VOTE_REQ    = 3'd2;
   localparam logic [2:0] KIND_APPEND_RPL  = 3'd3;
   localparam logic [2:0] KIND_VOTE_RPL    = 3'd4;

   localparam logic [1:0] ROLE_FOLLOWER    = 2'd0;
   localparam logic [1:0] ROLE_CANDIDATE   = 2'd1;
   localparam logic [1:0] ROLE_LEADER      = 2'd2;

   localparam logic [2:0] NOTE_PROMOTE     = 3'b001;
   localparam logic [2:0] NOTE_DEMOTE      = 3'b010;
   localparam logic [2:0] NOTE_LEADER      = 3'b100;

   localparam logic [3:0] NO_NODE          = 4'hF;

   localparam logic [2:0] CSR_NODE_COUNT   = 3'd0;
   localparam logic [2:0] CSR_SELF_INDEX   = 3'd1;
   localparam logic [2:0] CSR_ELECTION_TO  = 3'd2;
   localparam logic [2:0] CSR_HB_PERIOD    = 3'd3;
   localparam logic [2:0] CSR_LOSS_GRACE   = 3'd4;
   localparam logic [2:0] CSR_ELECTOR_ONLY = 3'd5;
   localparam logic [2:0] CSR_BLOCK_PROMO  = 3'd6;

   typedef struct packed {
      logic [3:0]  mode;
      logic        accepted;
      logic [2:0]  sender_index;
      logic [63:0] msg_term;
      logic [63:0] msg_time;
      logic [63:0] msg_version;
      logic        msg_result;
      logic [63:0] local_version;
   } req_type;

   typedef struct packed {
      logic [2:0]        send_kind;
      logic [7:0]        dest_mask;
      logic [63:0]       out_term;
      logic [63:0]       out_time;
      logic [63:0]       out_version;
      logic              out_result;
      logic [1:0]        role;
      logic              president;
      logic signed [3:0] leader_node;
      logic              restart_election;
      logic              start_loyalty;
      logic [2:0]        notices;
   } rsp_type;

   typedef struct packed {
      logic [63:0] heartbeat;
      logic        granted;
      logic        replied;
   } peer_type;

endpackage
`default_nettype wire

@@ sv/rln_peer_mem.sv @@
// Peer table memory: heartbeat tick and vote marks for each node.
// Depends on rln_pkg. Registered read; entries not written since
// the last clear read as zero, and vote marks also read as zero after a mark clear.
`default_nettype none
module rln_peer_mem
   import rln_pkg::*;
#(
   parameter int MAX_NODES = 8,
   parameter int IW = 3
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          clear,
   input  wire logic          clear_marks,
   input  wire logic          rd_en,
   input  wire logic [IW-1:0] rd_addr,
   input  wire logic          wr_en,
   input  wire logic [IW-1:0] wr_addr,
   input  wire peer_type      wr_data,
   output peer_type           rd_data
);

   peer_type               mem [MAX_NODES];
   logic [MAX_NODES-1:0]   valid_ff;
   logic [MAX_NODES-1:0]   valid_in;
   logic [MAX_NODES-1:0]   mark_ff;
   logic [MAX_NODES-1:0]   mark_in;
   peer_type               rd_data_ff;
   logic                   rd_mark_ff;

   always_comb begin
      valid_in = clear ? '0 : valid_ff;
      mark_in = (clear || clear_marks) ? '0 : mark_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
         mark_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mark_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         mark_ff <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
         rd_mark_ff <= mark_ff[rd_addr];
      end
   end

   // A mark clear keeps the heartbeat but hides the stale vote marks.
   assign rd_data = '{heartbeat: rd_data_ff.heartbeat,
                      granted: rd_data_ff.granted & rd_mark_ff,
                      replied: rd_data_ff.replied & rd_mark_ff};

endmodule
`default_nettype wire

@@ sv/raft_leader_election_node.sv @@
// Each item passes through dispatch (and, if accepted messages, execute) to output; a tick
// or a counted vote reply also walks the peer table through the WRD, W1, W2 and W3 states
// per entry, and a start runs a bit-serial timeout divide. One item at a time; the result
// register frees the input side while a result waits. Synchronous active-high
// reset clears the node state, restores register defaults and invalidates the table.
// Depends on rln_pkg and rln_peer_mem.
`default_nettype none
module raft_leader_election_node
   import rln_pkg::*;
#(
   parameter int MAX_NODES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = ($clog2(MAX_NODES + 1) > 4) ? $clog2(MAX_NODES + 1) : 4;
   localparam logic [IW-1:0] LAST = IW'(MAX_NODES - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_DIV    = 4'd3;
   localparam logic [3:0] S_SELFWR = 4'd4;
   localparam logic [3:0] S_ENTWR  = 4'd5;
   localparam logic [3:0] S_WRD    = 4'd6;
   localparam logic [3:0] S_W1     = 4'd7;
   localparam logic [3:0] S_W2     = 4'd8;
   localparam logic [3:0] S_W3     = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   logic [3:0]  state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [3:0]  node_count_ff;
   logic [2:0]  self_index_ff;
   logic [15:0] elec_to_ff;
   logic [15:0] hb_period_ff;
   logic [7:0]  grace_ff;
   logic        elector_ff;
   logic        block_ff;

   logic [63:0] term_ff, term_in;
   logic [1:0]  role_ff, role_in;
   logic        pres_ff, pres_in;
   logic [3:0]  leader_ff, leader_in;
   logic [3:0]  voted_ff, voted_in;
   logic [63:0] dver_ff, dver_in;
   logic [63:0] tick_ff, tick_in;
   logic        loyal_ff, loyal_in;
   logic [7:0]  streak_ff, streak_in;

   logic [IW-1:0]        walk_ff, walk_in;
   logic [CW-1:0]        loyal_cnt_ff, loyal_cnt_in;
   logic [CW-1:0]        grant_cnt_ff, grant_cnt_in;
   logic [MAX_NODES-1:0] repl_mask_ff, repl_mask_in;
   logic                 w_inr_ff, w_inr_in;
   logic                 w_def_ff, w_def_in;
   logic                 w_fresh_ff, w_fresh_in;
   logic [16:0]          w_dp1_ff, w_dp1_in;
   logic [32:0]          prod_ff, prod_in;
   logic [16:0]          div_rem_ff, div_rem_in;
   logic [15:0]          div_quo_ff, div_quo_in;
   logic [3:0]           div_cnt_ff, div_cnt_in;

   logic          mem_clear, mem_clear_marks, mem_rd_en, mem_wr_en;
   logic [IW-1:0] mem_rd_addr, mem_wr_addr;
   peer_type      mem_wr_data, mem_rd_data;

   logic [CW-1:0]        active;
   logic [CW-1:0]        quorum;
   logic [MAX_NODES-1:0] mask_others;
   logic [IW-1:0]        self_addr;
   logic [IW-1:0]        sender_addr;
   logic                 self_in_tab;
   logic                 sender_ok;

   rln_peer_mem #(
      .MAX_NODES(MAX_NODES),
      .IW       (IW)
   ) u_mem (
      .clock      (clock),
      .reset      (reset),
      .clear      (mem_clear),
      .clear_marks(mem_clear_marks),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_data    (mem_rd_data)
   );

   assign active = (32'(node_count_ff) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_ff);
   assign quorum = CW'({1'b0, node_count_ff[3:1]}) + CW'(1);
   assign self_addr = IW'(self_index_ff);
   assign sender_addr = IW'(req_ff.sender_index);
   assign self_in_tab = 32'(self_index_ff) < MAX_NODES;
   assign sender_ok = CW'(req_ff.sender_index) < active;

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         mask_others[i] = (CW'(i) < active) && (32'(self_index_ff) != i);
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      logic [63:0] dv_v;
      logic [63:0] term_v;
      logic [63:0] hb_v;
      logic [63:0] d_v;
      logic [16:0] rem_v;
      logic [15:0] quo_v;
      logic [15:0] per_v;
      logic [7:0]  streak_v;
      logic        grant_v;
      logic        fresh_v;
      logic        has_q_v;

      dv_v = dver_ff;
      term_v = term_ff;
      hb_v = '0;
      d_v = '0;
      rem_v = '0;
      quo_v = '0;
      per_v = '0;
      streak_v = '0;
      grant_v = 1'b0;
      fresh_v = 1'b0;
      has_q_v = 1'b0;

      state_in = state_ff;
      req_in = req_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      term_in = term_ff;
      role_in = role_ff;
      pres_in = pres_ff;
      leader_in = leader_ff;
      voted_in = voted_ff;
      dver_in = dver_ff;
      tick_in = tick_ff;
      loyal_in = loyal_ff;
      streak_in = streak_ff;
      walk_in = walk_ff;
      loyal_cnt_in = loyal_cnt_ff;
      grant_cnt_in = grant_cnt_ff;
      repl_mask_in = repl_mask_ff;
      w_inr_in = w_inr_ff;
      w_def_in = w_def_ff;
      w_fresh_in = w_fresh_ff;
      w_dp1_in = w_dp1_ff;
      prod_in = prod_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      mem_clear = 1'b0;
      mem_clear_marks = 1'b0;
      mem_rd_en = 1'b0;
      mem_rd_addr = walk_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = self_addr;
      mem_wr_data = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            walk_in = '0;
            loyal_cnt_in = '0;
            grant_cnt_in = '0;
            repl_mask_in = '0;
            state_in = S_OUT;
            case (req_ff.mode)
               MODE_TICK: begin
                  tick_in = tick_ff + 64'd1;
                  if (self_in_tab) begin
                     mem_rd_en = 1'b1;
                     mem_rd_addr = self_addr;
                     state_in = S_SELFWR;
                  end else begin
                     state_in = S_WRD;
                  end
               end
               MODE_TIMEOUT: begin
                  if (block_ff) begin
                     res_in.restart_election = 1'b1;
                  end else begin
                     term_v = term_ff + 64'd1;
                     role_in = ROLE_CANDIDATE;
                     term_in = term_v;
                     voted_in = {1'b0, self_index_ff};
                     // A new election drops the vote marks but keeps heartbeats.
                     mem_clear_marks = 1'b1;
                     if (self_in_tab) begin
                        mem_wr_en = 1'b1;
                        mem_wr_addr = self_addr;
                        mem_wr_data = '{heartbeat: tick_ff, granted: 1'b1, replied: 1'b1};
                     end
                     if (quorum > CW'(1)) begin
                        dv_v = elector_ff ? dver_ff : req_ff.local_version;
                        dver_in = dv_v;
                        // Right after the reset of the marks only this node
                        // has replied, so the unreplied mask is everyone else.
                        res_in.send_kind = KIND_VOTE_REQ;
                        res_in.dest_mask = 8'(mask_others);
                        res_in.out_term = term_v;
                        res_in.out_time = tick_ff;
                        res_in.out_version = dv_v;
                        res_in.restart_election = 1'b1;
                     end else begin
                        role_in = ROLE_LEADER;
                        leader_in = {1'b0, self_index_ff};
                        res_in.notices = res_ff.notices | NOTE_PROMOTE;
                     end
                  end
               end
               MODE_LOYAL_END: begin
                  loyal_in = 1'b0;
               end
               MODE_DEMOTE: begin
                  if (role_ff != ROLE_FOLLOWER) begin
                     role_in = ROLE_FOLLOWER;
                     pres_in = 1'b0;
                     voted_in = NO_NODE;
                     leader_in = NO_NODE;
                     streak_in = '0;
                     res_in.restart_election = 1'b1;
                  end
               end
               MODE_START: begin
                  mem_clear = 1'b1;
                  div_rem_in = '0;
                  div_quo_in = '0;
                  div_cnt_in = '0;
                  state_in = S_DIV;
               end
               MODE_APPEND, MODE_VOTE_REQ, MODE_APPEND_RPL, MODE_VOTE_RPL: begin
                  if (req_ff.accepted && sender_ok) begin
                     if (req_ff.msg_term > term_ff) begin
                        if (role_ff != ROLE_FOLLOWER) begin
                           res_in.notices = res_ff.notices | NOTE_DEMOTE;
                        end
                        term_in = req_ff.msg_term;
                        role_in = ROLE_FOLLOWER;
                        pres_in = 1'b0;
                        voted_in = NO_NODE;
                        leader_in = NO_NODE;
                        streak_in = '0;
                        res_in.restart_election = 1'b1;
                     end
                     state_in = S_EXEC;
                  end
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_DIV: begin
            // One quotient bit per cycle of election timeout / period.
            per_v = (hb_period_ff == 16'd0) ? 16'd1 : hb_period_ff;
            rem_v = {div_rem_ff[15:0], elec_to_ff[4'd15 - div_cnt_ff]};
            quo_v = {div_quo_ff[14:0], 1'b0};
            if (rem_v >= {1'b0, per_v}) begin
               rem_v = rem_v - {1'b0, per_v};
               quo_v[0] = 1'b1;
            end
            div_rem_in = rem_v;
            div_quo_in = quo_v;
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'd15) begin
               tick_in = 64'(quo_v) + 64'd1;
               if (role_ff != ROLE_LEADER) begin
                  res_in.restart_election = 1'b1;
               end
               loyal_in = 1'b1;
               res_in.start_loyalty = 1'b1;
               state_in = S_OUT;
            end
         end
         S_EXEC: begin
            state_in = S_OUT;
            case (req_ff.mode)
               MODE_APPEND: begin
                  res_in.send_kind = KIND_APPEND_RPL;
                  res_in.dest_mask = 8'd1 << req_ff.sender_index;
                  res_in.out_term = term_ff;
                  res_in.out_time = req_ff.msg_time;
                  if (req_ff.msg_term < term_ff) begin
                     res_in.out_version = dver_ff;
                     res_in.out_result = 1'b0;
                  end else begin
                     if (role_ff == ROLE_LEADER) begin
                        if (pres_ff) begin
                           res_in.notices = res_ff.notices | NOTE_DEMOTE;
                        end
                        pres_in = 1'b0;
                     end
                     if (elector_ff && (req_ff.msg_version > dver_ff)) begin
                        dv_v = req_ff.msg_version;
                     end
                     if ({1'b0, req_ff.sender_index} != leader_ff) begin
                        if (!elector_ff) begin
                           dv_v = req_ff.local_version;
                        end
                        res_in.notices = res_in.notices | NOTE_LEADER;
                     end
                     dver_in = dv_v;
                     leader_in = {1'b0, req_ff.sender_index};
                     loyal_in = 1'b1;
                     res_in.start_loyalty = 1'b1;
                     res_in.out_version = dv_v;
                     res_in.out_result = 1'b1;
                     role_in = ROLE_FOLLOWER;
                     res_in.restart_election = 1'b1;
                  end
               end
               MODE_VOTE_REQ: begin
                  if (voted_ff[3] && !elector_ff) begin
                     dv_v = req_ff.local_version;
                  end
                  dver_in = dv_v;
                  grant_v = (role_ff == ROLE_FOLLOWER) && (req_ff.msg_term >= term_ff) &&
                            (req_ff.msg_version >= dv_v) &&
                            ((loyal_ff && (leader_ff == {1'b0, req_ff.sender_index})) ||
                             (!loyal_ff && (voted_ff[3] ||
                                            (voted_ff == {1'b0, req_ff.sender_index}))));
                  res_in.send_kind = KIND_VOTE_RPL;
                  res_in.dest_mask = 8'd1 << req_ff.sender_index;
                  res_in.out_term = term_ff;
                  res_in.out_time = req_ff.msg_time;
                  res_in.out_version = dv_v;
                  res_in.out_result = grant_v;
                  if (grant_v) begin
                     voted_in = {1'b0, req_ff.sender_index};
                     res_in.restart_election = 1'b1;
                  end
               end
               MODE_APPEND_RPL: begin
                  if ((req_ff.msg_term >= term_ff) && (role_ff == ROLE_LEADER)) begin
                     mem_rd_en = 1'b1;
                     mem_rd_addr = sender_addr;
                     state_in = S_ENTWR;
                  end
               end
               MODE_VOTE_RPL: begin
                  if (req_ff.msg_term >= term_ff) begin
                     mem_rd_en = 1'b1;
                     mem_rd_addr = sender_addr;
                     state_in = S_ENTWR;
                  end
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_ENTWR: begin
            hb_v = (req_ff.msg_time > mem_rd_data.heartbeat) ? req_ff.msg_time
                                                             : mem_rd_data.heartbeat;
            mem_wr_en = 1'b1;
            mem_wr_addr = sender_addr;
            mem_wr_data = '{heartbeat: hb_v, granted: mem_rd_data.granted,
                            replied: mem_rd_data.replied};
            state_in = S_OUT;
            if (req_ff.mode == MODE_APPEND_RPL) begin
               mem_wr_data.granted = 1'b1;
               mem_wr_data.replied = 1'b1;
            end else if (role_ff == ROLE_CANDIDATE) begin
               mem_wr_data.granted = req_ff.msg_result;
               mem_wr_data.replied = 1'b1;
               state_in = S_WRD;
            end
         end
         S_SELFWR: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = self_addr;
            mem_wr_data = '{heartbeat: tick_ff, granted: mem_rd_data.granted,
                            replied: mem_rd_data.replied};
            state_in = S_WRD;
         end
         S_WRD: begin
            mem_rd_en = 1'b1;
            mem_rd_addr = walk_ff;
            state_in = S_W1;
         end
         S_W1: begin
            w_inr_in = CW'(walk_ff) < active;
            if (w_inr_in) begin
               grant_cnt_in = grant_cnt_ff + CW'(mem_rd_data.granted);
               repl_mask_in[walk_ff] = !mem_rd_data.replied;
            end
            d_v = tick_ff - mem_rd_data.heartbeat;
            w_dp1_in = {1'b0, d_v[15:0]} + 17'd1;
            if ((hb_period_ff == 16'd0) || (mem_rd_data.heartbeat > tick_ff)) begin
               w_def_in = 1'b1;
               w_fresh_in = 1'b1;
            end else if (d_v > 64'd65535) begin
               w_def_in = 1'b1;
               w_fresh_in = 1'b0;
            end else begin
               w_def_in = 1'b0;
               w_fresh_in = 1'b0;
            end
            state_in = S_W2;
         end
         S_W2: begin
            prod_in = {17'd0, hb_period_ff} * {16'd0, w_dp1_ff};
            state_in = S_W3;
         end
         S_W3: begin
            fresh_v = w_def_ff ? w_fresh_ff : (prod_ff <= {17'd0, elec_to_ff});
            if (w_inr_ff && fresh_v) begin
               loyal_cnt_in = loyal_cnt_ff + CW'(1);
            end
            if (walk_ff == LAST) begin
               state_in = S_FIN;
            end else begin
               walk_in = walk_ff + IW'(1);
               state_in = S_WRD;
            end
         end
         S_FIN: begin
            state_in = S_OUT;
            if (req_ff.mode == MODE_VOTE_RPL) begin
               if (grant_cnt_ff >= quorum) begin
                  role_in = ROLE_LEADER;
                  leader_in = {1'b0, self_index_ff};
                  res_in.send_kind = KIND_APPEND;
                  res_in.dest_mask = 8'(mask_others);
                  res_in.out_term = term_ff;
                  res_in.out_time = tick_ff;
                  res_in.out_version = dver_ff;
               end
            end else begin
               has_q_v = (role_ff == ROLE_LEADER) && (loyal_cnt_ff >= quorum);
               res_in.out_term = term_ff;
               res_in.out_time = tick_ff;
               res_in.out_version = dver_ff;
               if (pres_ff && !has_q_v) begin
                  streak_v = (streak_ff != 8'd255) ? streak_ff + 8'd1 : streak_ff;
                  streak_in = streak_v;
                  if (streak_v < grace_ff) begin
                     res_in.send_kind = KIND_APPEND;
                     res_in.dest_mask = 8'(mask_others);
                  end else begin
                     res_in.out_term = '0;
                     res_in.out_time = '0;
                     res_in.out_version = '0;
                     if (role_ff != ROLE_FOLLOWER) begin
                        res_in.notices = res_ff.notices | NOTE_DEMOTE;
                     end
                     role_in = ROLE_FOLLOWER;
                     pres_in = 1'b0;
                     voted_in = NO_NODE;
                     leader_in = NO_NODE;
                     streak_in = '0;
                     res_in.restart_election = 1'b1;
                  end
               end else begin
                  if (pres_ff) begin
                     streak_in = '0;
                  end
                  if (role_ff == ROLE_CANDIDATE) begin
                     res_in.send_kind = KIND_VOTE_REQ;
                     res_in.dest_mask = 8'(repl_mask_ff);
                  end else if (role_ff == ROLE_LEADER) begin
                     res_in.send_kind = KIND_APPEND;
                     res_in.dest_mask = 8'(mask_others);
                     if (!pres_ff && has_q_v) begin
                        pres_in = 1'b1;
                        res_in.notices = res_ff.notices | NOTE_PROMOTE;
                     end
                  end else begin
                     res_in.out_term = '0;
                     res_in.out_time = '0;
                     res_in.out_version = '0;
                  end
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = res_ff;
               rsp_in.role = role_ff;
               rsp_in.president = pres_ff;
               rsp_in.leader_node = leader_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         node_count_ff <= 4'd3;
         self_index_ff <= 3'd0;
         elec_to_ff <= 16'd300;
         hb_period_ff <= 16'd20;
         grace_ff <= 8'd5;
         elector_ff <= 1'b0;
         block_ff <= 1'b0;
         term_ff <= '0;
         role_ff <= ROLE_FOLLOWER;
         pres_ff <= 1'b0;
         leader_ff <= NO_NODE;
         voted_ff <= NO_NODE;
         dver_ff <= '0;
         tick_ff <= '0;
         loyal_ff <= 1'b0;
         streak_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         term_ff <= term_in;
         role_ff <= role_in;
         pres_ff <= pres_in;
         leader_ff <= leader_in;
         voted_ff <= voted_in;
         dver_ff <= dver_in;
         tick_ff <= tick_in;
         loyal_ff <= loyal_in;
         streak_ff <= streak_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_NODE_COUNT:   node_count_ff <= csr_data[3:0];
               CSR_SELF_INDEX:   self_index_ff <= csr_data[2:0];
               CSR_ELECTION_TO:  elec_to_ff <= csr_data;
               CSR_HB_PERIOD:    hb_period_ff <= csr_data;
               CSR_LOSS_GRACE:   grace_ff <= csr_data[7:0];
               CSR_ELECTOR_ONLY: elector_ff <= csr_data[0];
               CSR_BLOCK_PROMO:  block_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      walk_ff <= walk_in;
      loyal_cnt_ff <= loyal_cnt_in;
      grant_cnt_ff <= grant_cnt_in;
      repl_mask_ff <= repl_mask_in;
      w_inr_ff <= w_inr_in;
      w_def_ff <= w_def_in;
      w_fresh_ff <= w_fresh_in;
      w_dp1_ff <= w_dp1_in;
      prod_ff <= prod_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_cnt_ff <= div_cnt_in;
   end

endmodule
`default_nettype wire

@@ sv/rln_checker.sv @@
// Port-level checks for the leader election node, bound to the top level.
// Depends on rln_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rln_checker
   import rln_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   `RLN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `RLN_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall)

   `RLN_ASSERT_NOW(a_no_msg_zero, clock, reset, rsp_valid && (rsp_data.send_kind == KIND_NONE), (rsp_data.dest_mask == 8'd0) && (rsp_data.out_term == 64'd0) && (rsp_data.out_time == 64'd0) && (rsp_data.out_version == 64'd0) && !rsp_data.out_result)

   `RLN_ASSERT_NOW(a_reply_one_dest, clock, reset, rsp_valid && ((rsp_data.send_kind == KIND_APPEND_RPL) || (rsp_data.send_kind == KIND_VOTE_RPL)), $onehot(rsp_data.dest_mask))

endmodule

bind raft_leader_election_node rln_checker u_rln_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
`default_nettype wire
